[sv/gb3_pkg.sv]
package gb3_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int DIM_W       = 12;
    localparam int MAX_HEIGHT  = 2048;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // one column of the window for one channel: [0] row y-2, [1] row y-1, [2] row y
    typedef logic [2:0][SAMPLE_W-1:0] t_column;

    typedef struct packed {
        logic clear;
        logic shift;
        logic col_zero;
    } t_lane_ctrl;

    // zero counts as one, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                   input int limit);
        logic [DIM_W-1:0] res;
        if (raw == '0) begin
            res = DIM_W'(1);
        end else if (int'(raw) > limit) begin
            res = DIM_W'(limit);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

[sv/gb3_pix_in_if.sv]
interface gb3_pix_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [gb3_pkg::SAMPLE_W-1:0]  chan0_in;
    logic [gb3_pkg::SAMPLE_W-1:0]  chan1_in;
    logic [gb3_pkg::SAMPLE_W-1:0]  chan2_in;

    modport source (output valid, action, chan0_in, chan1_in, chan2_in, input ready);
    modport sink   (input valid, action, chan0_in, chan1_in, chan2_in, output ready);
endinterface

[sv/gb3_pix_out_if.sv]
interface gb3_pix_out_if;
    logic                          valid;
    logic                          ready;
    logic [gb3_pkg::SAMPLE_W-1:0]  chan0_out;
    logic [gb3_pkg::SAMPLE_W-1:0]  chan1_out;
    logic [gb3_pkg::SAMPLE_W-1:0]  chan2_out;
    logic                          frame_last;

    modport source (output valid, chan0_out, chan1_out, chan2_out, frame_last, input ready);
    modport sink   (input valid, chan0_out, chan1_out, chan2_out, frame_last, output ready);
endinterface

[sv/gb3_ram.sv]
module gb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/gb3_lane.sv]
module gb3_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gb3_pkg::t_lane_ctrl           i_ctrl,
    input  gb3_pkg::t_column              i_col,
    output logic [gb3_pkg::SAMPLE_W-1:0]  o_blur
);

    gb3_pkg::t_column r_win1;
    gb3_pkg::t_column r_win2;
    gb3_pkg::t_column right_col;

    logic [9:0]  v_left;
    logic [9:0]  v_mid;
    logic [9:0]  v_right;
    logic [11:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_win1 <= '0;
            r_win2 <= '0;
        end else if (i_ctrl.shift) begin
            r_win1 <= i_ctrl.col_zero ? '0 : r_win2;
            r_win2 <= i_col;
        end
    end

    // at column 0 the right edge of the output window lies outside the frame
    assign right_col = i_ctrl.col_zero ? '0 : i_col;

    assign v_left  = 10'(r_win1[0]) + {1'b0, r_win1[1], 1'b0} + 10'(r_win1[2]);
    assign v_mid   = 10'(r_win2[0]) + {1'b0, r_win2[1], 1'b0} + 10'(r_win2[2]);
    assign v_right = 10'(right_col[0]) + {1'b0, right_col[1], 1'b0} + 10'(right_col[2]);
    assign sum     = 12'(v_left) + {1'b0, v_mid, 1'b0} + 12'(v_right);
    assign o_blur  = sum[11:4];

endmodule

[sv/gaussian_blur_3x3_rgb_unit.sv]
// channel   dir  handshake      payload
// i_pix     in   valid/ready    action, chan0_in, chan1_in, chan2_in
// o_pix     out  valid/ready    chan0_out, chan1_out, chan2_out, frame_last
// i_cfg_*   in   write enable   index 0 frame_width, index 1 frame_height
//
// one item per clock while i_pix.ready is high; each item is decoded, read from the
// line buffer and summed in its accept cycle, and the result lands in the output register
// the line buffer ram read is issued ahead at the next column address, with a write
// bypass, so the single read port keeps up at full rate
// i_pix.ready is low only while a result sits in the output register and o_pix.ready is low
// synchronous reset clears position, window and output valid; line buffer is not cleared
// a register write restarts the frame
module gaussian_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int CHANNELS  = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gb3_pkg::DIM_W-1:0]       i_cfg_data,
    gb3_pix_in_if.sink                      i_pix,
    gb3_pix_out_if.source                   o_pix
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (AW > gb3_pkg::DIM_W) ? AW : gb3_pkg::DIM_W;
    localparam int LW = CHANNELS * gb3_pkg::SAMPLE_W;
    localparam int SW = gb3_pkg::SAMPLE_W;
    localparam int DW = gb3_pkg::DIM_W;

    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;
    logic [AW-1:0] r_col;
    logic [AW-1:0] n_col;
    logic [DW-1:0] r_row;
    logic [DW-1:0] n_row;

    logic          r_byp;
    logic [2*LW-1:0] r_byp_data;
    logic [2*LW-1:0] ram_q;
    logic [2*LW-1:0] line_rd;
    logic [2*LW-1:0] line_wr;

    logic          in_ready;
    logic          accept;
    logic          in_frame;
    logic          col_last;
    logic          emit;
    logic          is_last;

    logic          r_out_valid;
    logic          r_out_last;
    logic [SW-1:0] r_out_chan [3];

    logic [SW-1:0] all_samp [4];
    logic [SW-1:0] blur_ext [4];
    logic [SW-1:0] lane_blur [CHANNELS];
    gb3_pkg::t_column   lane_col [CHANNELS];
    gb3_pkg::t_lane_ctrl lane_ctrl;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gb3_pkg::clamp_dim(DW'(gb3_pkg::RESET_WIDTH), MAX_WIDTH);
            r_height <= gb3_pkg::clamp_dim(DW'(gb3_pkg::RESET_HEIGHT), gb3_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gb3_pkg::CFG_FRAME_WIDTH: begin
                    r_width <= gb3_pkg::clamp_dim(i_cfg_data, MAX_WIDTH);
                end
                gb3_pkg::CFG_FRAME_HEIGHT: begin
                    r_height <= gb3_pkg::clamp_dim(i_cfg_data, gb3_pkg::MAX_HEIGHT);
                end
                default: begin
                end
            endcase
        end
    end

    assign in_ready    = !r_out_valid || o_pix.ready;
    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;

    assign in_frame = !i_pix.action && (r_row < r_height);
    assign col_last = (CW'(r_col) + CW'(1)) == CW'(r_width);
    assign emit     = (r_row >= DW'(2)) || ((r_row == DW'(1)) && (r_col != '0));
    // last output pixel shows up one row and one column past the frame
    assign is_last  = (r_row == r_height + DW'(1)) && (r_col == '0);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (emit && is_last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_last) begin
                n_col = '0;
                n_row = r_row + DW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffer word: upper line above, middle line below
    always_comb begin
        all_samp[0] = i_pix.chan0_in;
        all_samp[1] = i_pix.chan1_in;
        all_samp[2] = i_pix.chan2_in;
        all_samp[3] = '0;
    end

    assign line_rd = r_byp ? r_byp_data : ram_q;

    always_comb begin
        line_wr = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            lane_col[k][0] = (r_row >= DW'(2)) ? line_rd[LW + k*SW +: SW] : '0;
            lane_col[k][1] = (r_row >= DW'(1)) ? line_rd[k*SW +: SW] : '0;
            lane_col[k][2] = in_frame ? all_samp[k] : '0;
            line_wr[LW + k*SW +: SW] = lane_col[k][1];
            line_wr[k*SW +: SW]      = lane_col[k][2];
        end
    end

    gb3_ram #(
        .WIDTH (2*LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (line_wr),
        .i_raddr (n_col),
        .o_rdata (ram_q)
    );

    // read of the column being written in the same cycle takes the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= accept && (r_col == n_col);
        end
        r_byp_data <= line_wr;
    end

    assign lane_ctrl.clear    = i_cfg_we;
    assign lane_ctrl.shift    = accept;
    assign lane_ctrl.col_zero = (r_col == '0);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            blur_ext[k] = '0;
        end
        for (int k = 0; k < CHANNELS; k++) begin
            blur_ext[k] = lane_blur[k];
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        gb3_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (lane_ctrl),
            .i_col   (lane_col[g]),
            .o_blur  (lane_blur[g])
        );
    end

    // merge the lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_ready) begin
            r_out_valid <= accept && emit;
        end
        if (accept && emit) begin
            r_out_chan[0] <= blur_ext[0];
            r_out_chan[1] <= blur_ext[1];
            r_out_chan[2] <= blur_ext[2];
            r_out_last    <= is_last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.chan0_out  = r_out_chan[0];
    assign o_pix.chan1_out  = r_out_chan[1];
    assign o_pix.chan2_out  = r_out_chan[2];
    assign o_pix.frame_last = r_out_last;

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < CW'(r_width))
        else $error("column position past frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_height + DW'(1))
        else $error("row position past drain row");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && emit && is_last |=> (r_col == '0) && (r_row == '0))
        else $error("frame did not restart after last item");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> r_out_valid)
        else $error("input stalled with empty output register");

endmodule
